// ===== sv/cbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbrd_pkg
// Shared widths, types, register codes and helpers of the bank register decoder.
// ----------------------------------------------------------------------------
package cbrd_pkg;

	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int PRG_W    = 4;
	localparam int MIRROR_W = 2;
	localparam int PAT_W    = 8;
	localparam int NUM_PRG  = 2;
	localparam int NUM_PAT  = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// top address nibble decodes
	localparam logic [3:0] TOP_PRG0      = 4'h8;
	localparam logic [3:0] TOP_MIRROR    = 4'h9;
	localparam logic [3:0] TOP_PRG1      = 4'hA;
	localparam logic [3:0] TOP_PAT_FIRST = 4'hB;
	localparam logic [3:0] TOP_PAT_LAST  = 4'hE;

	localparam logic [7:0] PRG_MAX_RST = 8'd15;
	localparam logic [7:0] CHR_MAX_RST = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REVISION = 2'd0,
		CFG_PRG_MAX  = 2'd1,
		CFG_CHR_MAX  = 2'd2
	} cfg_idx_t;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef struct packed {
		logic [NUM_PRG-1:0][PRG_W-1:0] prg;
		logic [MIRROR_W-1:0]           mirror;
		logic [NUM_PAT-1:0][PAT_W-1:0] pat;
	} bank_state_t;

	// a bank above its maximum is masked by the maximum
	function automatic logic [7:0] limit_bank(input logic [7:0] v, input logic [7:0] mx);
		return (v > mx) ? (v & mx) : v;
	endfunction

	function automatic bank_state_t reset_state();
		bank_state_t s;
		s.prg    = '0;
		s.mirror = '0;
		for (int i = 0; i < NUM_PAT; i++) begin
			s.pat[i] = PAT_W'(i);
		end
		return s;
	endfunction

endpackage

// ===== sv/cbrd_if.sv =====
// ----------------------------------------------------------------------------
// cbrd channel interfaces
// Valid/ready channels for CPU write items and bank result items.
// ----------------------------------------------------------------------------
interface cbrd_in_if import cbrd_pkg::*; ();
	logic  valid;
	logic  ready;
	addr_t cpu_address;
	data_t write_data;

	modport source (output valid, cpu_address, write_data, input ready);
	modport sink   (input valid, cpu_address, write_data, output ready);
endinterface

interface cbrd_out_if import cbrd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PRG_W-1:0]    prg_bank_first;
	logic [PRG_W-1:0]    prg_bank_second;
	logic [MIRROR_W-1:0] mirror_mode;
	logic [PAT_W-1:0]    pattern_bank_0;
	logic [PAT_W-1:0]    pattern_bank_1;
	logic [PAT_W-1:0]    pattern_bank_2;
	logic [PAT_W-1:0]    pattern_bank_3;
	logic [PAT_W-1:0]    pattern_bank_4;
	logic [PAT_W-1:0]    pattern_bank_5;
	logic [PAT_W-1:0]    pattern_bank_6;
	logic [PAT_W-1:0]    pattern_bank_7;

	modport source (output valid, prg_bank_first, prg_bank_second, mirror_mode,
		pattern_bank_0, pattern_bank_1, pattern_bank_2, pattern_bank_3,
		pattern_bank_4, pattern_bank_5, pattern_bank_6, pattern_bank_7,
		input ready);
	modport sink (input valid, prg_bank_first, prg_bank_second, mirror_mode,
		pattern_bank_0, pattern_bank_1, pattern_bank_2, pattern_bank_3,
		pattern_bank_4, pattern_bank_5, pattern_bank_6, pattern_bank_7,
		output ready);
endinterface

// ===== sv/cbrd_bank_update.sv =====
// ----------------------------------------------------------------------------
// cbrd_bank_update
// Decodes one CPU write and computes the next banking register file.
// ----------------------------------------------------------------------------
module cbrd_bank_update import cbrd_pkg::*; (
	input  logic        revision,
	input  logic [7:0]  prg_bank_max,
	input  logic [7:0]  chr_bank_max,
	input  addr_t       cpu_address,
	input  data_t       write_data,
	input  bank_state_t cur,
	output bank_state_t nxt
);

	logic [3:0]       top;
	logic             a0;
	logic             a1;
	logic [3:0]       pat_ofs;
	logic [2:0]       slot;
	logic [3:0]       nib;
	logic [PAT_W-1:0] pat_merged;
	logic [PRG_W-1:0] prg_lim;

	assign top = cpu_address[15:12];

	// revision 1 boards swap A0 and A1
	assign a0 = revision ? cpu_address[1] : cpu_address[0];
	assign a1 = revision ? cpu_address[0] : cpu_address[1];

	assign pat_ofs = top - TOP_PAT_FIRST;
	assign slot    = {pat_ofs[1:0], a1};
	assign nib     = revision ? write_data[4:1] : write_data[3:0];

	assign pat_merged = a0 ? {nib, cur.pat[slot][3:0]} : {cur.pat[slot][7:4], nib};
	assign prg_lim    = PRG_W'(limit_bank({4'b0, write_data[3:0]}, prg_bank_max));

	always_comb begin
		nxt = cur;
		priority if (top == TOP_PRG0) begin
			nxt.prg[0] = prg_lim;
		end else if (top == TOP_PRG1) begin
			nxt.prg[1] = prg_lim;
		end else if (top == TOP_MIRROR) begin
			nxt.mirror = write_data[MIRROR_W-1:0];
		end else if (top >= TOP_PAT_FIRST && top <= TOP_PAT_LAST) begin
			nxt.pat[slot] = limit_bank(pat_merged, chr_bank_max);
		end else begin
			nxt = cur;
		end
	end

endmodule

// ===== sv/cartridge_bank_register_decoder_core.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_register_decoder_core
// Bank switching register file driven by CPU writes; returns all banks per write.
// ----------------------------------------------------------------------------
// A write item passes the input register, then the register file. Throughput: one
// item per cycle unless results stall; the input register feeds the bank update
// logic, which loads the register file that doubles as the result register.
// Reset: banks clear to zero, pattern bank i to i, revision 0, program max 15,
// pattern max 255; both channels come up empty.
module cartridge_bank_register_decoder_core import cbrd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cbrd_in_if.sink               in_ch,
	cbrd_out_if.source            out_ch
);

	logic        revision_q;
	logic [7:0]  prg_max_q;
	logic [7:0]  chr_max_q;

	logic        valid_s1;
	addr_t       addr_s1;
	data_t       data_s1;

	bank_state_t state_q;
	bank_state_t state_nxt;
	logic        out_valid_q;
	logic        advance;

	// the register file is only updated when the result slot is free
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			revision_q <= 1'b0;
			prg_max_q  <= PRG_MAX_RST;
			chr_max_q  <= CHR_MAX_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_REVISION: revision_q <= cfg_data[0];
				CFG_PRG_MAX:  prg_max_q  <= cfg_data;
				CFG_CHR_MAX:  chr_max_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			addr_s1 <= in_ch.cpu_address;
			data_s1 <= in_ch.write_data;
		end
	end

	cbrd_bank_update u_update (
		.revision     (revision_q),
		.prg_bank_max (prg_max_q),
		.chr_bank_max (chr_max_q),
		.cpu_address  (addr_s1),
		.write_data   (data_s1),
		.cur          (state_q),
		.nxt          (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= reset_state();
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.prg_bank_first  = state_q.prg[0];
	assign out_ch.prg_bank_second = state_q.prg[1];
	assign out_ch.mirror_mode     = state_q.mirror;
	assign out_ch.pattern_bank_0  = state_q.pat[0];
	assign out_ch.pattern_bank_1  = state_q.pat[1];
	assign out_ch.pattern_bank_2  = state_q.pat[2];
	assign out_ch.pattern_bank_3  = state_q.pat[3];
	assign out_ch.pattern_bank_4  = state_q.pat[4];
	assign out_ch.pattern_bank_5  = state_q.pat[5];
	assign out_ch.pattern_bank_6  = state_q.pat[6];
	assign out_ch.pattern_bank_7  = state_q.pat[7];

endmodule

// ===== tb/sv/cartridge_bank_register_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_register_decoder_core_tb
// Drives CPU write items into the bank register decoder with random gaps and
// back-pressure. Every returned bank file is checked against a tracked copy of
// the program, mirroring and pattern registers under several limit settings.
// ----------------------------------------------------------------------------
module cartridge_bank_register_decoder_core_tb;
	import cbrd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
	localparam logic [3:0]           TOP_UNMAPPED = 4'hF;
	localparam int                   PRINT_CAP    = 200;

	class bank_file_checker;
		logic [PRG_W-1:0]    prg_slot [NUM_PRG];
		logic [MIRROR_W-1:0] mirror;
		logic [PAT_W-1:0]    pat_slot [NUM_PAT];
		logic                revision;
		logic [7:0]          prg_cap;
		logic [7:0]          chr_cap;
		bank_state_t         expected_banks [$];
		int                  mismatches;

		function new();
			revision = 1'b0;
			prg_cap  = PRG_MAX_RST;
			chr_cap  = CHR_MAX_RST;
			mirror   = '0;
			foreach (prg_slot[i]) prg_slot[i] = '0;
			foreach (pat_slot[i]) pat_slot[i] = PAT_W'(i);
			mismatches = 0;
		endfunction

		function int pending();
			return expected_banks.size();
		endfunction

		function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_REVISION: revision = val[0];
				CFG_PRG_MAX:  prg_cap  = val;
				CFG_CHR_MAX:  chr_cap  = val;
				default: ;
			endcase
		endfunction

		function logic [7:0] capped(logic [7:0] v, logic [7:0] mx);
			return (v > mx) ? (v & mx) : v;
		endfunction

		function void note_write(addr_t a, data_t d);
			logic [3:0]       top;
			logic [3:0]       win;
			logic             hi_sel;
			logic             row_sel;
			logic [2:0]       slot;
			data_t            shifted;
			logic [7:0]       v;
			bank_state_t      snap;
			top = a[15:12];
			if (a < 16'hB000) begin
				if (top == TOP_PRG0 || top == TOP_PRG1) begin
					v = capped({4'h0, d[3:0]}, prg_cap);
					prg_slot[(top == TOP_PRG0) ? 0 : 1] = v[3:0];
				end else if (top == TOP_MIRROR) begin
					mirror = d[1:0];
				end
			end else if (top <= TOP_PAT_LAST) begin
				// revision 1 boards swap A0/A1
				hi_sel  = revision ? a[1] : a[0];
				row_sel = revision ? a[0] : a[1];
				win     = top - TOP_PAT_FIRST;
				slot    = {win[1:0], row_sel};
				shifted = d >> revision;
				if (hi_sel)
					v = {shifted[3:0], pat_slot[slot][3:0]};
				else
					v = {pat_slot[slot][7:4], shifted[3:0]};
				pat_slot[slot] = capped(v, chr_cap);
			end
			snap.prg[0] = prg_slot[0];
			snap.prg[1] = prg_slot[1];
			snap.mirror = mirror;
			for (int i = 0; i < NUM_PAT; i++) snap.pat[i] = pat_slot[i];
			expected_banks.push_back(snap);
		endfunction

		task report(string what, int got, int want);
			if (mismatches < PRINT_CAP)
				$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_banks(bank_state_t seen);
			bank_state_t want;
			if (expected_banks.size() == 0) begin
				report("unexpected result item", 0, 0);
				return;
			end
			want = expected_banks.pop_front();
			if (seen.prg[0] !== want.prg[0]) report("prg_bank_first", seen.prg[0], want.prg[0]);
			if (seen.prg[1] !== want.prg[1]) report("prg_bank_second", seen.prg[1], want.prg[1]);
			if (seen.mirror !== want.mirror) report("mirror_mode", seen.mirror, want.mirror);
			for (int i = 0; i < NUM_PAT; i++) begin
				if (seen.pat[i] !== want.pat[i])
					report($sformatf("pattern_bank_%0d", i), seen.pat[i], want.pat[i]);
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cbrd_in_if  in_ch();
	cbrd_out_if out_ch();

	bank_file_checker banks = new();

	int tx_calm_left = 0;
	int rx_calm_left = 0;
	int rx_stall_left = 0;

	addr_t dir_addr [0:23] = '{
		16'h8000, 16'h8FFF, 16'h9000, 16'h9123, 16'hA000, 16'hAFFF,
		16'hB000, 16'hB001, 16'hB002, 16'hB003, 16'hCFFC, 16'hC005,
		16'hD00A, 16'hDFFF, 16'hE000, 16'hE003, 16'hEFFE, 16'hE001,
		16'hF000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h9000
	};
	data_t dir_data [0:23] = '{
		8'hFF, 8'h0A, 8'hFF, 8'h02, 8'h0F, 8'hF5,
		8'h0F, 8'hFF, 8'h03, 8'h0C, 8'hA5, 8'h5A,
		8'h11, 8'h22, 8'h00, 8'hFF, 8'h77, 8'h80,
		8'hFF, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00
	};

	cartridge_bank_register_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_ch        (in_ch),
		.out_ch       (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int idle_cycles(ref int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic addr_t random_address();
		int         pick;
		logic [11:0] low;
		logic [3:0]  win;
		pick = $urandom_range(0, 99);
		low  = 12'($urandom_range(0, 4095));
		win  = TOP_PAT_FIRST + 4'($urandom_range(0, 3));
		if (pick < 10) return {TOP_PRG0, low};
		if (pick < 20) return {TOP_MIRROR, low};
		if (pick < 30) return {TOP_PRG1, low};
		if (pick < 85) return {win, low};
		if (pick < 95) return {TOP_UNMAPPED, low};
		return addr_t'($urandom_range(0, 16'h7FFF));
	endfunction

	task automatic put_write(input addr_t a, input data_t d);
		int gap;
		gap = idle_cycles(tx_calm_left);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.cpu_address <= a;
		in_ch.write_data  <= d;
		do @(posedge clk); while (!in_ch.ready);
		banks.note_write(a, d);
	endtask

	task automatic run_writes(input int count);
		for (int i = 0; i < count; i++)
			put_write(random_address(), data_t'($urandom_range(0, 255)));
		in_ch.valid <= 1'b0;
		while (banks.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		banks.note_register(idx, val);
	endtask

	// called only with the block drained
	task automatic set_registers(input logic rev, input logic [7:0] prg_max,
		input logic [7:0] chr_max, input bit touch_spare);
		if (touch_spare)
			write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
		write_reg(CFG_REVISION, {7'h0, rev});
		write_reg(CFG_PRG_MAX, prg_max);
		write_reg(CFG_CHR_MAX, chr_max);
		cfg_write_en <= 1'b0;
	endtask

	always @(posedge clk) begin : result_drain
		bank_state_t seen;
		int          stall;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				seen.prg[0] = out_ch.prg_bank_first;
				seen.prg[1] = out_ch.prg_bank_second;
				seen.mirror = out_ch.mirror_mode;
				seen.pat[0] = out_ch.pattern_bank_0;
				seen.pat[1] = out_ch.pattern_bank_1;
				seen.pat[2] = out_ch.pattern_bank_2;
				seen.pat[3] = out_ch.pattern_bank_3;
				seen.pat[4] = out_ch.pattern_bank_4;
				seen.pat[5] = out_ch.pattern_bank_5;
				seen.pat[6] = out_ch.pattern_bank_6;
				seen.pat[7] = out_ch.pattern_bank_7;
				banks.check_banks(seen);
			end
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				stall = idle_cycles(rx_calm_left);
				if (stall > 0) begin
					rx_stall_left = stall - 1;
					out_ch.ready <= 1'b0;
				end else begin
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_write_en      = 1'b0;
		cfg_index         = CFG_REVISION;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.cpu_address = '0;
		in_ch.write_data  = '0;
		out_ch.ready      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decode corners at reset limits
		for (int i = 0; i < 24; i++)
			put_write(dir_addr[i], dir_data[i]);
		run_writes(150);

		set_registers(1'b1, 8'd0, 8'd0, 1'b0);
		run_writes(170);
		set_registers(1'b0, 8'd255, 8'd255, 1'b1);
		run_writes(170);
		set_registers(1'b1, 8'd7, 8'h3F, 1'b0);
		run_writes(170);
		set_registers(1'b0, 8'd5, 8'h9A, 1'b0);
		run_writes(170);
		repeat (2) begin
			set_registers(1'($urandom_range(0, 1)), 8'($urandom_range(0, 15)),
				8'($urandom_range(0, 255)), 1'b0);
			run_writes(150);
		end

		repeat (4) @(posedge clk);
		if (banks.mismatches == 0 && banks.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/cbrd_pkg.sv
sv/cbrd_if.sv
sv/cbrd_bank_update.sv
sv/cartridge_bank_register_decoder_core.sv
tb/sv/cartridge_bank_register_decoder_core_tb.sv
